FILE: sv/rmq_pkg.sv
// shared item types and codes for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;

  // input item: nine matrix entries, row-major
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [1:0]         branch;
    logic               degenerate;
  } out_t;

  // branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // register indexes
  localparam int REG_TRACE_THRESHOLD = 0;

  // quotient magnitude bits produced by the divider lanes
  localparam int QBITS = 17;
  // width of a signed entry sum or difference
  localparam int NBITS = 17;

endpackage
`default_nettype wire

FILE: sv/rmq_front.sv
// front end: branch choice, radicand and numerator sums for one item
`default_nettype none
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 18
) (
  input  in_t                     item,
  input  logic [15:0]             trace_threshold,
  output logic [1:0]              br,
  output logic [RW-1:0]           rad,
  output logic signed [NBITS-1:0] n0,
  output logic signed [NBITS-1:0] n1,
  output logic signed [NBITS-1:0] n2
);

  localparam logic signed [RW:0] ONE_S = (RW+1)'(1) << FRAC_BITS;

  logic signed [RW:0] e00, e11, e22, thr_s, diag, r1, r2, r3, rsel;
  logic signed [NBITS-1:0] m01, m02, m10, m12, m20, m21;

  // widened operands
  assign e00   = (RW+1)'(item.m00);
  assign e11   = (RW+1)'(item.m11);
  assign e22   = (RW+1)'(item.m22);
  assign thr_s = signed'({{(RW+1-16){1'b0}}, trace_threshold});
  assign m01   = NBITS'(item.m01);
  assign m02   = NBITS'(item.m02);
  assign m10   = NBITS'(item.m10);
  assign m12   = NBITS'(item.m12);
  assign m20   = NBITS'(item.m20);
  assign m21   = NBITS'(item.m21);

  // candidate radicands
  assign diag = ONE_S + e00 + e11 + e22;
  assign r1   = ONE_S + e00 - e11 - e22;
  assign r2   = ONE_S + e11 - e00 - e22;
  assign r3   = ONE_S + e22 - e00 - e11;

  // branch select and off-diagonal sums
  always_comb begin
    if (diag > thr_s) begin
      br = BR_TRACE; rsel = diag;
      n0 = m21 - m12; n1 = m02 - m20; n2 = m10 - m01;
    end else if (item.m00 > item.m11 && item.m00 > item.m22) begin
      br = BR_X; rsel = r1;
      n0 = m21 - m12; n1 = m10 + m01; n2 = m02 + m20;
    end else if (item.m11 > item.m22) begin
      br = BR_Y; rsel = r2;
      n0 = m02 - m20; n1 = m10 + m01; n2 = m21 + m12;
    end else begin
      br = BR_Z; rsel = r3;
      n0 = m10 - m01; n1 = m02 + m20; n2 = m21 + m12;
    end
  end

  // negative radicand clamps to zero
  assign rad = rsel[RW] ? '0 : rsel[RW-1:0];

endmodule
`default_nettype wire

FILE: sv/rmq_queue.sv
// two-entry queue between front and back
`default_nettype none
module rmq_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [0:1];
  logic         wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rmq_back.sv
// back end: pipelined square root, three divider lanes, saturation
`default_nettype none
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 18
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_take,
  input  logic [1:0]              in_br,
  input  logic [RW-1:0]           in_rad,
  input  logic signed [NBITS-1:0] in_n0,
  input  logic signed [NBITS-1:0] in_n1,
  input  logic signed [NBITS-1:0] in_n2,
  output logic                    out_valid,
  input  logic                    out_pop,
  output out_t                    out_data
);

  localparam int XW = RW + FRAC_BITS;
  localparam int HW = (XW + 1) / 2;
  localparam int PW = 2 * HW;
  localparam int NW = NBITS + FRAC_BITS;
  localparam int CW = (NW > HW + QBITS + 1) ? NW : HW + QBITS + 1;

  logic en;
  logic out_valid_r;
  out_t out_data_r;

  // whole pipeline moves unless the result register is held
  assign en        = ~out_valid_r | out_pop;
  assign in_take   = en & in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // square root stages
  logic                    sv_r    [0:HW];
  logic [PW-1:0]           sx_r    [0:HW];
  logic [HW+1:0]           srem_r  [0:HW];
  logic [HW-1:0]           sroot_r [0:HW];
  logic [1:0]              sbr_r   [0:HW];
  logic signed [NBITS-1:0] sn_r    [0:HW][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0]    <= PW'(in_rad) << FRAC_BITS;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sbr_r[0]   <= in_br;
      sn_r[0][0] <= in_n0;
      sn_r[0][1] <= in_n1;
      sn_r[0][2] <= in_n2;
    end
  end

  genvar gs;
  generate
    for (gs = 1; gs <= HW; gs++) begin : g_sqrt
      logic [HW+1:0] rem_sh, trial;
      logic          ge;
      // one root bit per stage
      assign rem_sh = {srem_r[gs-1][HW-1:0], sx_r[gs-1][PW-1 -: 2]};
      assign trial  = {sroot_r[gs-1], 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r[gs] <= 1'b0;
        end else if (en) begin
          sv_r[gs] <= sv_r[gs-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sx_r[gs]    <= sx_r[gs-1] << 2;
          srem_r[gs]  <= ge ? (rem_sh - trial) : rem_sh;
          sroot_r[gs] <= {sroot_r[gs-1][HW-2:0], ge};
          sbr_r[gs]   <= sbr_r[gs-1];
          sn_r[gs]    <= sn_r[gs-1];
        end
      end
    end
  endgenerate

  // divider stages, stage zero is the setup
  logic             dv_r   [0:QBITS];
  logic [HW-1:0]    dh_r   [0:QBITS];
  logic [1:0]       dbr_r  [0:QBITS];
  logic [HW:0]      dden_r [0:QBITS];
  logic [CW-1:0]    drem_r [0:QBITS][0:2];
  logic [QBITS-1:0] dq_r   [0:QBITS][0:2];
  logic             dneg_r [0:QBITS][0:2];
  logic             dovf_r [0:QBITS][0:2];

  logic [HW:0]      den0;
  logic [CW-1:0]    num0 [0:2];
  logic [NBITS-1:0] mag0 [0:2];

  assign den0 = {sroot_r[HW], 1'b0};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag0[j] = sn_r[HW][j][NBITS-1] ? NBITS'(-sn_r[HW][j]) : NBITS'(sn_r[HW][j]);
      num0[j] = CW'(mag0[j]) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sv_r[HW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dh_r[0]   <= sroot_r[HW];
      dbr_r[0]  <= sbr_r[HW];
      dden_r[0] <= den0;
      for (int j = 0; j < 3; j++) begin
        drem_r[0][j] <= num0[j];
        dq_r[0][j]   <= '0;
        dneg_r[0][j] <= sn_r[HW][j][NBITS-1];
        dovf_r[0][j] <= (num0[j] >= (CW'(den0) << QBITS));
      end
    end
  end

  genvar gd;
  generate
    for (gd = 1; gd <= QBITS; gd++) begin : g_div
      logic [CW-1:0] dsh;
      logic          ge [0:2];
      // one quotient bit per stage in each lane
      assign dsh = CW'(dden_r[gd-1]) << (QBITS - gd);
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          ge[j] = (drem_r[gd-1][j] >= dsh);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[gd] <= 1'b0;
        end else if (en) begin
          dv_r[gd] <= dv_r[gd-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dh_r[gd]   <= dh_r[gd-1];
          dbr_r[gd]  <= dbr_r[gd-1];
          dden_r[gd] <= dden_r[gd-1];
          for (int j = 0; j < 3; j++) begin
            drem_r[gd][j] <= ge[j] ? (drem_r[gd-1][j] - dsh) : drem_r[gd-1][j];
            dq_r[gd][j]   <= {dq_r[gd-1][j][QBITS-2:0], ge[j]};
            dneg_r[gd][j] <= dneg_r[gd-1][j];
            dovf_r[gd][j] <= dovf_r[gd-1][j];
          end
        end
      end
    end
  endgenerate

  // signed saturation of a quotient magnitude
  function automatic logic signed [15:0] sat_q(input logic [QBITS-1:0] mag,
                                               input logic neg, input logic ovf);
    logic signed [15:0] res;
    if (neg) begin
      if (ovf || mag > QBITS'(32768)) res = 16'sh8000;
      else res = 16'(-mag);
    end else begin
      if (ovf || mag > QBITS'(32767)) res = 16'sh7fff;
      else res = 16'(mag);
    end
    return res;
  endfunction

  // final assembly
  logic signed [15:0] comp [0:3];
  logic signed [15:0] oth  [0:2];
  logic signed [15:0] mainc;
  logic               degen;
  logic [31:0]        half_h;
  out_t               res;

  assign degen  = (dh_r[QBITS] == '0);
  assign half_h = 32'(dh_r[QBITS] >> 1);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      oth[j] = sat_q(dq_r[QBITS][j], dneg_r[QBITS][j], dovf_r[QBITS][j]);
    end
    mainc = (half_h > 32'd32767) ? 16'sh7fff : 16'(half_h);
    case (dbr_r[QBITS])
      BR_TRACE: begin comp[0] = mainc;  comp[1] = oth[0]; comp[2] = oth[1]; comp[3] = oth[2]; end
      BR_X:     begin comp[0] = oth[0]; comp[1] = mainc;  comp[2] = oth[1]; comp[3] = oth[2]; end
      BR_Y:     begin comp[0] = oth[0]; comp[1] = oth[1]; comp[2] = mainc;  comp[3] = oth[2]; end
      default:  begin comp[0] = oth[0]; comp[1] = oth[1]; comp[2] = oth[2]; comp[3] = mainc;  end
    endcase
    res.qw         = degen ? 16'sd0 : comp[0];
    res.qx         = degen ? 16'sd0 : comp[1];
    res.qy         = degen ? 16'sd0 : comp[2];
    res.qz         = degen ? 16'sd0 : comp[3];
    res.branch     = dbr_r[QBITS];
    res.degenerate = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res;
    end
  end

  // degenerate results carry no components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.degenerate |->
      out_data_r.qw == 16'sd0 && out_data_r.qx == 16'sd0 &&
      out_data_r.qy == 16'sd0 && out_data_r.qz == 16'sd0)
    else $error("degenerate result with nonzero component");

  // trace branch scalar part comes from the root and is never negative
  a_trace_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.branch == BR_TRACE |-> !out_data_r.qw[15])
    else $error("negative scalar part on trace branch");

  // a held result stays valid until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |=> out_valid_r)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

FILE: sv/rotation_matrix_to_quaternion.sv
// top level: config register, front end, decoupling queue, back end
// RW = max(FRAC_BITS, 17) + 1 is the radicand width
// throughput: one item per cycle while the result register is not held,
//   set by the fully pipelined root and divider stages
// the back end stalls as a whole while the result register waits to be popped
// reset: synchronous active low, clears valid bits and trace_threshold to zero
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_t         in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int QW = 2 + RW + 3 * NBITS;

  // configuration register
  logic [15:0] thr_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 2'(REG_TRACE_THRESHOLD * 4)) ? {16'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd0;
    end else if (cfg_wr) begin
      thr_r <= cfg_pwdata[15:0];
    end
  end

  // front end
  logic [1:0]              f_br;
  logic [RW-1:0]           f_rad;
  logic signed [NBITS-1:0] f_n0, f_n1, f_n2;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .item            (in_data),
    .trace_threshold (thr_r),
    .br              (f_br),
    .rad             (f_rad),
    .n0              (f_n0),
    .n1              (f_n1),
    .n2              (f_n2)
  );

  // queue between front and back
  logic [QW-1:0] q_rdata;
  logic          q_empty, b_take;

  rmq_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata ({f_br, f_rad, f_n0, f_n1, f_n2}),
    .pop   (b_take),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back end
  logic b_valid;

  rmq_back #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (~q_empty),
    .in_take   (b_take),
    .in_br     (q_rdata[QW-1 -: 2]),
    .in_rad    (q_rdata[QW-3 -: RW]),
    .in_n0     (signed'(q_rdata[3*NBITS-1 -: NBITS])),
    .in_n1     (signed'(q_rdata[2*NBITS-1 -: NBITS])),
    .in_n2     (signed'(q_rdata[NBITS-1:0])),
    .out_valid (b_valid),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  assign out_empty = ~b_valid;

endmodule
`default_nettype wire
